@@ sv/tvg_pkg.sv @@
`default_nettype none
package tvg_pkg;
  localparam int unsigned CfgAddrW = 5;
  localparam logic [CfgAddrW-1:0] AddrViewX = 5'd0;
  localparam logic [CfgAddrW-1:0] AddrViewY = 5'd4;
  localparam logic [CfgAddrW-1:0] AddrViewZ = 5'd8;
  localparam logic [CfgAddrW-1:0] AddrNearGain = 5'd12;
  localparam logic [CfgAddrW-1:0] AddrFarGain = 5'd16;
  localparam int unsigned DivSteps = 31;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0] obj_error;
    logic [31:0] bound_radius;
    logic signed [31:0] left_z;
    logic signed [31:0] right_z;
  } vtx_in_t;

  typedef struct packed {
    logic active;
    logic signed [31:0] morph_z;
  } vtx_out_t;

  typedef struct packed {
    logic signed [31:0] view_x;
    logic signed [31:0] view_y;
    logic signed [31:0] view_z;
    logic [31:0] near_gain;
    logic [31:0] far_gain;
  } cfg_t;

  // Work carried from the distance front end to the divider and morph stages.
  typedef struct packed {
    logic active;
    logic morph;
    logic signed [31:0] z;
    logic signed [33:0] delta;
    logic [30:0] span;
    logic [30:0] part;
  } front_t;
endpackage
`default_nettype wire

@@ sv/tvg_if.sv @@
`default_nettype none
interface tvg_in_if;
  import tvg_pkg::*;
  logic valid;
  logic ready;
  vtx_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tvg_out_if;
  import tvg_pkg::*;
  logic valid;
  logic ready;
  vtx_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/tvg_front.sv @@
`default_nettype none
module tvg_front
  import tvg_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    en_i,
  input  wire logic    vld_i,
  input  wire vtx_in_t in_i,
  input  wire cfg_t    cfg_i,
  output logic         vld_o,
  output front_t       out_o
);
  // Stage 1: differences and gain products.
  logic [2:0] vld_q;
  logic [32:0] dx_q, dy_q, dz_q;
  logic [63:0] fp_q, np_q;
  logic [31:0] rad_q;
  logic signed [31:0] z1_q, z2_q, z3_q;
  logic signed [33:0] dl1_q, dl2_q, dl3_q;
  // Stage 2: squares and sphere terms.
  logic [65:0] dsum_q;
  logic [32:0] tf_q, tn_q;
  // Stage 3: sphere squares.
  logic [63:0] d3_q, dmax_q, dmin_q;

  logic signed [32:0] ddx, ddy, ddz;
  logic [32:0] tf_d, tn_d;
  logic [63:0] d_sat, span_w, part_w;
  logic [5:0] sh;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : v;
  endfunction

  function automatic logic [63:0] sq_sat(input logic [32:0] t);
    sq_sat = t[32] ? '1 : 64'(t[31:0]) * 64'(t[31:0]);
  endfunction

  always_comb begin
    ddx = 33'(in_i.pos_x) - 33'(cfg_i.view_x);
    ddy = 33'(in_i.pos_y) - 33'(cfg_i.view_y);
    ddz = 33'(in_i.pos_z) - 33'(cfg_i.view_z);
    tf_d = 33'(fp_q[55:24]) + 33'(rad_q);
    tn_d = 33'(np_q[55:24]) + 33'(rad_q);
    // A scaled error above 32 bits forces the sphere size to saturate.
    if (|fp_q[63:56]) tf_d[32] = 1'b1;
    if (|np_q[63:56]) tn_d[32] = 1'b1;
    d_sat = (dsum_q[65:64] != 2'b00) ? '1 : dsum_q[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= mag33(ddx);
      dy_q <= mag33(ddy);
      dz_q <= mag33(ddz);
      fp_q <= 64'(cfg_i.far_gain) * 64'(in_i.obj_error);
      np_q <= 64'(cfg_i.near_gain) * 64'(in_i.obj_error);
      rad_q <= in_i.bound_radius;
      z1_q <= in_i.pos_z;
      dl1_q <= 34'(in_i.left_z) + 34'(in_i.right_z) - (34'(in_i.pos_z) <<< 1);
      dsum_q <= 66'(64'(dx_q) * 64'(dx_q)) + 66'(64'(dy_q) * 64'(dy_q))
              + 66'(64'(dz_q) * 64'(dz_q));
      tf_q <= tf_d;
      tn_q <= tn_d;
      z2_q <= z1_q;
      dl2_q <= dl1_q;
      d3_q <= d_sat;
      dmax_q <= sq_sat(tf_q);
      dmin_q <= sq_sat(tn_q);
      z3_q <= z2_q;
      dl3_q <= dl2_q;
    end
  end

  // Normalize span and part by the same shift so the span fits 31 bits.
  always_comb begin
    span_w = dmax_q - dmin_q;
    part_w = d3_q - dmin_q;
    sh = '0;
    for (int i = 63; i >= 31; i--) begin
      if (span_w[i] && sh == 6'd0) sh = 6'(i - 30);
    end
    out_o.active = dmax_q > d3_q;
    out_o.morph = !(dmin_q > d3_q);
    out_o.z = z3_q;
    out_o.delta = dl3_q;
    out_o.span = 31'(span_w >> sh);
    out_o.part = 31'(part_w >> sh);
  end

  assign vld_o = vld_q[2];
endmodule
`default_nettype wire

@@ sv/tvg_div.sv @@
`default_nettype none
module tvg_div
  import tvg_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   en_i,
  input  wire logic   vld_i,
  input  wire front_t in_i,
  output logic        vld_o,
  output front_t      out_o,
  output logic [30:0] quo_o
);
  // Restoring divider, one quotient bit per stage: (part << 30) / span.
  // The loaded stage handles bit 30; stages 1..30 handle the rest.
  logic [DivSteps-1:0] vld_q;
  front_t ctx_q [DivSteps];
  logic [31:0] rem_q [DivSteps];
  logic [30:0] q_q [DivSteps];
  logic [31:0] r0;

  always_comb begin
    r0 = {1'b0, in_i.part};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivSteps-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q[0] <= in_i;
      if (r0 >= {1'b0, in_i.span}) begin
        rem_q[0] <= r0 - {1'b0, in_i.span};
        q_q[0] <= 31'd1;
      end else begin
        rem_q[0] <= r0;
        q_q[0] <= 31'd0;
      end
      for (int k = 1; k < DivSteps; k++) begin
        logic [32:0] r;
        r = {rem_q[k-1], 1'b0};
        ctx_q[k] <= ctx_q[k-1];
        if (r >= {2'b0, ctx_q[k-1].span}) begin
          rem_q[k] <= 32'(r - {2'b0, ctx_q[k-1].span});
          q_q[k] <= {q_q[k-1][29:0], 1'b1};
        end else begin
          rem_q[k] <= 32'(r);
          q_q[k] <= {q_q[k-1][29:0], 1'b0};
        end
      end
    end
  end

  assign vld_o = vld_q[DivSteps-1];
  assign out_o = ctx_q[DivSteps-1];
  assign quo_o = q_q[DivSteps-1];
endmodule
`default_nettype wire

@@ sv/tvg_morph.sv @@
`default_nettype none
module tvg_morph
  import tvg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        vld_i,
  input  wire front_t      in_i,
  input  wire logic [30:0] quo_i,
  output logic             vld_o,
  output vtx_out_t         out_o
);
  logic [1:0] vld_q;
  logic signed [65:0] prod_q;
  logic act_q, mor_q;
  logic signed [31:0] z_q;
  vtx_out_t res_q;
  logic signed [35:0] sum;

  always_comb begin
    sum = 36'(prod_q >>> 31) + 36'(z_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 66'($signed({1'b0, quo_i})) * 66'(in_i.delta);
      act_q <= in_i.active;
      mor_q <= in_i.morph;
      z_q <= in_i.z;
      res_q.active <= act_q;
      if (!act_q) res_q.morph_z <= '0;
      else if (!mor_q) res_q.morph_z <= z_q;
      else if (sum > 36'sh07FFFFFFF) res_q.morph_z <= 32'h7FFFFFFF;
      else if (sum < -36'sh080000000) res_q.morph_z <= 32'h80000000;
      else res_q.morph_z <= sum[31:0];
    end
  end

  assign vld_o = vld_q[1];
  assign out_o = res_q;
endmodule
`default_nettype wire

@@ sv/terrain_vertex_geomorph_top.sv @@
`default_nettype none
// From input transfer to result the pipeline has 3 distance stages,
// 31 divider stages and 2 morph stages; throughput is one vertex per
// cycle when not stalled. The whole pipeline advances together; it
// stalls only when the output holds a result that is not taken and the
// last stage is full. Reset (rst_ni, asynchronous, active low) clears
// valid bits and all configuration registers to zero.
module terrain_vertex_geomorph_top
  import tvg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  tvg_in_if.sink                   in_if,
  tvg_out_if.source                out_if,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  cfg_t cfg_q;
  logic en, f_vld, d_vld;
  front_t f_out, d_out;
  logic [30:0] quo;

  assign pready = 1'b1;

  // Register writes complete in the APB access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        AddrViewX: cfg_q.view_x <= pwdata;
        AddrViewY: cfg_q.view_y <= pwdata;
        AddrViewZ: cfg_q.view_z <= pwdata;
        AddrNearGain: cfg_q.near_gain <= pwdata;
        AddrFarGain: cfg_q.far_gain <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrViewX: prdata = cfg_q.view_x;
      AddrViewY: prdata = cfg_q.view_y;
      AddrViewZ: prdata = cfg_q.view_z;
      AddrNearGain: prdata = cfg_q.near_gain;
      AddrFarGain: prdata = cfg_q.far_gain;
      default: prdata = '0;
    endcase
  end

  // The last morph stage is the output register; everything moves when
  // it is empty or its result transfers this cycle.
  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  tvg_front u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_if.valid), .in_i(in_if.data),
    .cfg_i(cfg_q), .vld_o(f_vld), .out_o(f_out)
  );

  tvg_div u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(f_vld), .in_i(f_out),
    .vld_o(d_vld), .out_o(d_out), .quo_o(quo)
  );

  tvg_morph u_morph (
    .clk_i, .rst_ni, .en_i(en), .vld_i(d_vld), .in_i(d_out), .quo_i(quo),
    .vld_o(out_if.valid), .out_o(out_if.data)
  );
endmodule
`default_nettype wire
